// ----- hw/rtl/pfbi_pkg.sv -----
// ============================================================================
// pfbi_pkg: shared types and constants for the floppy bit-stream interface
// Register codes, request kinds and the bit positions of port A and port B.
// ============================================================================
package pfbi_pkg;

    typedef enum logic [1:0] {
        REQ_READ  = 2'd0,
        REQ_WRITE = 2'd1,
        REQ_TICK  = 2'd2
    } req_type_t;

    typedef enum logic [1:0] {
        ADDR_PORT_A = 2'd0,
        ADDR_CTRL_A = 2'd1,
        ADDR_PORT_B = 2'd2,
        ADDR_CTRL_B = 2'd3
    } reg_addr_t;

    typedef enum logic [2:0] {
        CFG_FLOPPY_ON       = 3'd0,
        CFG_BIT_INTERVAL    = 3'd1,
        CFG_HOLE_BITS       = 3'd2,
        CFG_REVOLUTION_BITS = 3'd3,
        CFG_DRIVES_LOADED   = 3'd4
    } cfg_index_t;

    localparam int CR_DATA_ACCESS_BIT  = 2;
    localparam int PA_D0_NOT_READY_BIT = 0;
    localparam int PA_NOT_TRACK0_BIT   = 1;
    localparam int PA_D1_NOT_READY_BIT = 4;
    localparam int PA_WRITABLE_BIT     = 5;
    localparam int PA_SELECT_D0_BIT    = 6;
    localparam int PA_NOT_HOLE_BIT     = 7;
    localparam int PB_DRIVE_ON_BIT     = 5;
    localparam int PB_HEAD_LIFT_BIT    = 7;

    localparam logic [7:0]  OUT_A_RESET        = 8'hFF;
    localparam logic [7:0]  MASK_FIRST_BIT     = 8'h80;
    localparam logic [6:0]  HEAD_TRACK_FIXED   = 7'd7;
    localparam logic [23:0] ACCUM_MAX          = 24'hFFFFFF;
    localparam logic [15:0] BIT_INTERVAL_RESET = 16'd2048;
    localparam logic [15:0] HOLE_BITS_RESET    = 16'd687;
    localparam logic [15:0] REV_BITS_RESET     = 16'd25000;

    typedef struct packed {
        logic        byte_wanted;
        logic [12:0] fetch_pos;
        logic [6:0]  fetch_track;
        logic        fetch_drive;
        logic        index_hole;
        logic        disk_bit;
        logic        bit_valid;
        logic [7:0]  read_data;
    } result_t;

endpackage

// ----- hw/rtl/pia_floppy_bitstream_interface_core.sv -----
// ============================================================================
// pia_floppy_bitstream_interface_core: parallel port chip with floppy stream
// Register reads and writes of a two-port parallel interface, plus ticks that
// advance a Q16.8 bit clock, the revolution count, the index hole and the
// serial disk bit.
// ============================================================================
//
//  channel   direction  signals                    payload
//  s_axis    in         s_tvalid/s_tready          tuser: req_type
//                       s_tdata, s_tuser           tdata: reg_addr, write_data,
//                                                  tick_cycles, disk_byte
//  m_axis    out        m_tvalid/m_tready/m_tdata  result fields, one per item
//  cfg       in         cfg_we/cfg_addr/cfg_wdata  five config registers
//
// Each beat passes an input register and then a result register, whose value
// is shown on m_tdata. The throughput is one beat per cycle while m_tready is
// high; when the output stalls, the input register holds and s_tready drops.
// Reset puts the config, port and stream state registers and both valid flags
// into their power-on values at once; input data and result are not reset.
module pia_floppy_bitstream_interface_core
    import pfbi_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [1:0] reg_addr, [9:2] write_data, [17:10] tick_cycles, [25:18] disk_byte
    input  logic [31:0] s_tdata,
    // [1:0] req_type
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [7:0] read_data, [8] bit_valid, [9] disk_bit, [10] index_hole,
    // [11] fetch_drive, [18:12] fetch_track, [31:19] fetch_pos, [32] byte_wanted
    output logic [39:0] m_tdata,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_addr,
    input  logic [15:0] cfg_wdata
);

    logic        floppy_on_reg;
    logic [15:0] bit_interval_reg;
    logic [15:0] hole_bits_reg;
    logic [15:0] rev_bits_reg;
    logic [1:0]  drives_loaded_reg;

    logic        in_valid_reg;
    logic [1:0]  in_req_reg;
    logic [1:0]  in_addr_reg;
    logic [7:0]  in_wdata_reg;
    logic [7:0]  in_cycles_reg;
    logic [7:0]  in_disk_reg;
    logic        in_move;

    logic        out_valid_reg;
    result_t     out_result_reg;
    result_t     result;

    logic [7:0]  ctrl_a_reg, ctrl_a_next;
    logic [7:0]  ctrl_b_reg, ctrl_b_next;
    logic [7:0]  dir_a_reg, dir_a_next;
    logic [7:0]  dir_b_reg, dir_b_next;
    logic [7:0]  out_a_reg, out_a_next;
    logic [7:0]  out_b_reg, out_b_next;
    logic        sel_reg, sel_next;
    logic [23:0] accum_reg, accum_next;
    logic [15:0] bit_count_reg, bit_count_next;
    logic        hole_reg, hole_next;
    logic [12:0] byte_pos_reg [2];
    logic [12:0] byte_pos_next [2];
    logic [7:0]  bit_mask_reg [2];
    logic [7:0]  bit_mask_next [2];
    logic [7:0]  shift_byte_reg [2];
    logic [7:0]  shift_byte_next [2];

    logic [24:0] accum_sum;
    logic [23:0] accum_sat;
    logic        tick_gated;
    logic        bit_time;
    logic [16:0] cnt_inc;
    logic        rev_end;
    logic [15:0] cnt_new;
    logic [7:0]  mask_cur;
    logic [12:0] pos_cur;
    logic        load_byte;
    logic [7:0]  shift_cur;
    logic        bit_out;
    logic        shift_now;
    logic [7:0]  pa_inputs;
    logic [7:0]  rd_value;
    logic [16:0] next_cnt_inc;
    logic        next_rev_end;

    assign in_move  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || in_move;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_result_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            floppy_on_reg     <= 1'b0;
            bit_interval_reg  <= BIT_INTERVAL_RESET;
            hole_bits_reg     <= HOLE_BITS_RESET;
            rev_bits_reg      <= REV_BITS_RESET;
            drives_loaded_reg <= 2'd0;
        end
        else if (cfg_we)
        begin
            case (cfg_index_t'(cfg_addr))
                CFG_FLOPPY_ON:       floppy_on_reg     <= cfg_wdata[0];
                CFG_BIT_INTERVAL:    bit_interval_reg  <= cfg_wdata;
                CFG_HOLE_BITS:       hole_bits_reg     <= cfg_wdata;
                CFG_REVOLUTION_BITS: rev_bits_reg      <= cfg_wdata;
                CFG_DRIVES_LOADED:   drives_loaded_reg <= cfg_wdata[1:0];
                default:             ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_req_reg    <= s_tuser;
            in_addr_reg   <= s_tdata[1:0];
            in_wdata_reg  <= s_tdata[9:2];
            in_cycles_reg <= s_tdata[17:10];
            in_disk_reg   <= s_tdata[25:18];
        end
    end

    // Bit clock and revolution arithmetic for a tick.
    assign accum_sum  = {1'b0, accum_reg} + {9'd0, in_cycles_reg, 8'd0};
    assign accum_sat  = accum_sum[24] ? ACCUM_MAX : accum_sum[23:0];
    assign tick_gated = floppy_on_reg && out_b_reg[PB_DRIVE_ON_BIT];
    assign bit_time   = tick_gated && (accum_sat >= {8'd0, bit_interval_reg});
    assign cnt_inc    = {1'b0, bit_count_reg} + 17'd1;
    assign rev_end    = cnt_inc >= {1'b0, rev_bits_reg};
    assign cnt_new    = rev_end ? 16'd0 : cnt_inc[15:0];
    assign mask_cur   = rev_end ? 8'd0 : bit_mask_reg[sel_reg];
    assign pos_cur    = rev_end ? 13'd0 : byte_pos_reg[sel_reg];
    assign load_byte  = (mask_cur == 8'd0);
    assign shift_cur  = load_byte ? in_disk_reg : shift_byte_reg[sel_reg];
    assign bit_out    = load_byte ? in_disk_reg[7] : |(shift_cur & mask_cur);
    assign shift_now  = bit_time && !out_b_reg[PB_HEAD_LIFT_BIT];

    always_comb
    begin
        pa_inputs = 8'd0;
        pa_inputs[PA_D0_NOT_READY_BIT] = !drives_loaded_reg[0];
        pa_inputs[PA_NOT_TRACK0_BIT]   = (HEAD_TRACK_FIXED != 7'd0);
        pa_inputs[PA_D1_NOT_READY_BIT] = !drives_loaded_reg[1];
        pa_inputs[PA_WRITABLE_BIT]     = drives_loaded_reg[sel_reg];
        pa_inputs[PA_SELECT_D0_BIT]    = !sel_reg;
        pa_inputs[PA_NOT_HOLE_BIT]     = !hole_reg;
    end

    always_comb
    begin
        case (reg_addr_t'(in_addr_reg))
            ADDR_PORT_A:
                rd_value = ctrl_a_reg[CR_DATA_ACCESS_BIT]
                         ? ((pa_inputs & ~dir_a_reg) | (out_a_reg & dir_a_reg))
                         : dir_a_reg;
            ADDR_CTRL_A:
                rd_value = ctrl_a_reg;
            ADDR_PORT_B:
                rd_value = ctrl_b_reg[CR_DATA_ACCESS_BIT]
                         ? (out_b_reg & dir_b_reg) : dir_b_reg;
            default:
                rd_value = ctrl_b_reg;
        endcase
    end

    always_comb
    begin
        ctrl_a_next     = ctrl_a_reg;
        ctrl_b_next     = ctrl_b_reg;
        dir_a_next      = dir_a_reg;
        dir_b_next      = dir_b_reg;
        out_a_next      = out_a_reg;
        out_b_next      = out_b_reg;
        sel_next        = sel_reg;
        accum_next      = accum_reg;
        bit_count_next  = bit_count_reg;
        hole_next       = hole_reg;
        byte_pos_next   = byte_pos_reg;
        bit_mask_next   = bit_mask_reg;
        shift_byte_next = shift_byte_reg;
        result.read_data = 8'd0;
        result.bit_valid = 1'b0;
        result.disk_bit  = 1'b0;
        case (req_type_t'(in_req_reg))
            REQ_READ:
            begin
                result.read_data = rd_value;
            end
            REQ_WRITE:
            begin
                case (reg_addr_t'(in_addr_reg))
                    ADDR_PORT_A:
                    begin
                        if (!ctrl_a_reg[CR_DATA_ACCESS_BIT])
                        begin
                            dir_a_next = in_wdata_reg;
                        end
                        else
                        begin
                            out_a_next = in_wdata_reg;
                            if (dir_a_reg[PA_SELECT_D0_BIT])
                            begin
                                sel_next = !in_wdata_reg[PA_SELECT_D0_BIT];
                            end
                        end
                    end
                    ADDR_CTRL_A:
                        ctrl_a_next = in_wdata_reg;
                    ADDR_PORT_B:
                    begin
                        if (!ctrl_b_reg[CR_DATA_ACCESS_BIT])
                        begin
                            dir_b_next = in_wdata_reg;
                        end
                        else
                        begin
                            out_b_next = in_wdata_reg;
                        end
                    end
                    default:
                        ctrl_b_next = in_wdata_reg;
                endcase
            end
            REQ_TICK:
            begin
                if (tick_gated)
                begin
                    accum_next = bit_time ? (accum_sat - {8'd0, bit_interval_reg})
                                          : accum_sat;
                end
                if (bit_time)
                begin
                    bit_count_next = cnt_new;
                    hole_next      = (cnt_new < hole_bits_reg);
                    byte_pos_next[sel_reg] = pos_cur;
                    bit_mask_next[sel_reg] = mask_cur;
                end
                if (shift_now)
                begin
                    if (load_byte)
                    begin
                        shift_byte_next[sel_reg] = in_disk_reg;
                        byte_pos_next[sel_reg]   = pos_cur + 13'd1;
                        bit_mask_next[sel_reg]   = MASK_FIRST_BIT >> 1;
                    end
                    else
                    begin
                        bit_mask_next[sel_reg] = mask_cur >> 1;
                    end
                    result.bit_valid = 1'b1;
                    result.disk_bit  = bit_out;
                end
            end
            default:
            begin
            end
        endcase

        next_cnt_inc = {1'b0, bit_count_next} + 17'd1;
        next_rev_end = next_cnt_inc >= {1'b0, rev_bits_reg};
        result.index_hole  = hole_next;
        result.fetch_drive = sel_next;
        result.fetch_track = HEAD_TRACK_FIXED;
        result.fetch_pos   = next_rev_end ? 13'd0 : byte_pos_next[sel_next];
        result.byte_wanted = next_rev_end || (bit_mask_next[sel_next] == 8'd0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_a_reg        <= 8'd0;
            ctrl_b_reg        <= 8'd0;
            dir_a_reg         <= 8'd0;
            dir_b_reg         <= 8'd0;
            out_a_reg         <= OUT_A_RESET;
            out_b_reg         <= 8'd0;
            sel_reg           <= 1'b0;
            accum_reg         <= 24'd0;
            bit_count_reg     <= 16'd0;
            hole_reg          <= 1'b0;
            byte_pos_reg[0]   <= 13'd0;
            byte_pos_reg[1]   <= 13'd0;
            bit_mask_reg[0]   <= 8'd0;
            bit_mask_reg[1]   <= 8'd0;
            shift_byte_reg[0] <= 8'd0;
            shift_byte_reg[1] <= 8'd0;
        end
        else if (in_move)
        begin
            ctrl_a_reg     <= ctrl_a_next;
            ctrl_b_reg     <= ctrl_b_next;
            dir_a_reg      <= dir_a_next;
            dir_b_reg      <= dir_b_next;
            out_a_reg      <= out_a_next;
            out_b_reg      <= out_b_next;
            sel_reg        <= sel_next;
            accum_reg      <= accum_next;
            bit_count_reg  <= bit_count_next;
            hole_reg       <= hole_next;
            byte_pos_reg   <= byte_pos_next;
            bit_mask_reg   <= bit_mask_next;
            shift_byte_reg <= shift_byte_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_move)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_move)
        begin
            out_result_reg <= result;
        end
    end

endmodule
